/* sv/dqp_pkg.sv */
// Shared types, character codes and helpers for the dotted-quad and netmask parser.
`default_nettype none
package dqp_pkg;

  // Character codes the parser reacts to.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // The CIDR length saturates here, one past the longest legal prefix.
  localparam logic [5:0] CIDR_SAT = 6'd33;
  localparam logic [5:0] CIDR_MAX = 6'd32;
  localparam logic [31:0] ALL_ONES = 32'hffff_ffff;

  // Where the number reader stands within one field.
  typedef enum logic [1:0] {
    PH_SKIPWS = 2'd0,
    PH_DIGITS = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  // Complete parser state carried from one character to the next.
  typedef struct packed {
    logic [3:0][7:0] octet_store;
    logic [7:0]      octet_accum;
    phase_t          field_phase;
    logic            negative_seen;
    logic [1:0]      dot_count;
    logic            dots_done;
    logic            string_ended;
    logic            at_first_char;
    logic            mode_latched;
    logic            cidr_mode;
    logic [5:0]      prefix_count;
  } parse_st_t;

  function automatic parse_st_t reset_state();
    parse_st_t s;
    s               = '0;
    s.field_phase   = PH_SKIPWS;
    s.at_first_char = 1'b1;
    return s;
  endfunction

  // Space and the control characters TAB through CR count as whitespace.
  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  // Value of the current octet field, with a minus sign taken modulo 256.
  function automatic logic [7:0] field_value(input parse_st_t s);
    return s.negative_seen ? (8'd0 - s.octet_accum) : s.octet_accum;
  endfunction

endpackage
`default_nettype wire

/* sv/dqp_parse_core.sv */
// Per-character state update of the parser and its state register.
`default_nettype none
module dqp_parse_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire logic [7:0]        ch,
  input  wire logic              last,
  input  wire logic              func,
  output dqp_pkg::parse_st_t     st_upd
);

  dqp_pkg::parse_st_t st_r;
  dqp_pkg::parse_st_t st_nxt;

  logic       first;
  logic       mode;
  logic       digit;
  logic [3:0] dval;
  logic [8:0] prefix_sum;
  logic [7:0] accum_sum;

  assign first      = st_r.at_first_char;
  assign mode       = first ? func : st_r.mode_latched;
  assign digit      = (ch >= dqp_pkg::CH_ZERO) && (ch <= dqp_pkg::CH_NINE);
  assign dval       = 4'(ch - dqp_pkg::CH_ZERO);
  assign prefix_sum = 9'(st_r.prefix_count) * 9'd10 + 9'(dval);
  assign accum_sum  = 8'(st_r.octet_accum * 8'd10) + 8'(dval);

  always_comb begin
    logic take;
    take   = 1'b0;
    st_upd = st_r;
    st_upd.mode_latched  = mode;
    st_upd.at_first_char = 1'b0;
    if (!st_r.string_ended) begin
      if (ch == dqp_pkg::CH_NUL) begin
        st_upd.string_ended = 1'b1;
      end else if (first && mode && (ch == dqp_pkg::CH_SLASH)) begin
        st_upd.cidr_mode = 1'b1;
      end else if (!st_r.cidr_mode && (ch == dqp_pkg::CH_DOT) && !st_r.dots_done) begin
        st_upd.octet_store[st_r.dot_count] = dqp_pkg::field_value(st_r);
        st_upd.octet_accum   = '0;
        st_upd.negative_seen = 1'b0;
        st_upd.field_phase   = dqp_pkg::PH_SKIPWS;
        st_upd.dot_count     = st_r.dot_count + 2'd1;
        if (st_r.dot_count == 2'd2) begin
          st_upd.dots_done = 1'b1;
        end
      end else begin
        unique case (st_r.field_phase)
          dqp_pkg::PH_SKIPWS: begin
            if (dqp_pkg::is_ws(ch)) begin
              st_upd.field_phase = dqp_pkg::PH_SKIPWS;
            end else if ((ch == dqp_pkg::CH_PLUS) || (ch == dqp_pkg::CH_MINUS)) begin
              st_upd.negative_seen = (ch == dqp_pkg::CH_MINUS);
              st_upd.field_phase   = dqp_pkg::PH_DIGITS;
            end else if (digit) begin
              take               = 1'b1;
              st_upd.field_phase = dqp_pkg::PH_DIGITS;
            end else begin
              st_upd.field_phase = dqp_pkg::PH_DONE;
            end
          end
          dqp_pkg::PH_DIGITS: begin
            if (digit) begin
              take = 1'b1;
            end else begin
              st_upd.field_phase = dqp_pkg::PH_DONE;
            end
          end
          default: begin
          end
        endcase
        if (take) begin
          if (st_r.cidr_mode) begin
            st_upd.prefix_count = (prefix_sum > 9'(dqp_pkg::CIDR_SAT)) ?
                                  dqp_pkg::CIDR_SAT : prefix_sum[5:0];
          end else begin
            st_upd.octet_accum = accum_sum;
          end
        end
      end
    end
  end

  // The string's last character returns everything to the reset state.
  always_comb begin
    st_nxt = st_r;
    if (step) begin
      st_nxt = last ? dqp_pkg::reset_state() : st_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= dqp_pkg::reset_state();
    end else begin
      st_r <= st_nxt;
    end
  end

endmodule
`default_nettype wire

/* sv/dqp_result.sv */
// Builds the 32-bit address or mask from the parser state after the last character.
`default_nettype none
module dqp_result (
  input  wire dqp_pkg::parse_st_t st,
  output logic [31:0]             value
);

  logic [5:0]  shamt;
  logic [31:0] quad;

  assign shamt = dqp_pkg::CIDR_MAX - st.prefix_count;
  assign quad  = st.dots_done ?
                 {st.octet_store[0], st.octet_store[1], st.octet_store[2],
                  dqp_pkg::field_value(st)} : 32'd0;

  always_comb begin
    if (st.cidr_mode) begin
      if (st.negative_seen || (st.prefix_count == 6'd0) ||
          (st.prefix_count > dqp_pkg::CIDR_MAX)) begin
        value = 32'd0;
      end else begin
        value = dqp_pkg::ALL_ONES << shamt;
      end
    end else if (st.mode_latched && !quad[31]) begin
      value = ~quad;
    end else begin
      value = quad;
    end
  end

endmodule
`default_nettype wire

/* sv/dotted_quad_and_netmask_parser.sv */
// Top level of the dotted-quad and CIDR netmask parser.
`default_nettype none
//
//  Channel  | Ports                                 | Word
//  ---------+---------------------------------------+-----------------------------------
//  input    | in_valid, in_stall, in_ch, in_last,   | one character of the string,
//           | in_func                               | mode taken from the first one
//  result   | out_valid, out_stall, out_value       | 32-bit address or mask, one per
//           |                                       | string, after its last character
//
// Each character is captured in an input register; the state update and the
// final value are formed from that register in one pass of logic, and for a
// string's last character the result is loaded into the output register,
// from which it is taken once the receiver does not stall.
// A new character is taken every cycle; only a last character that meets a
// full, stalled output register waits. Reset (synchronous, rst_n low) clears
// both registers' valid flags and puts the parser at the start of a string.
module dotted_quad_and_netmask_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_ch,
  input  wire logic        in_last,
  input  wire logic        in_func,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_value
);

  // Input register.
  logic        s1_valid_r;
  logic        s1_valid_nxt;
  logic [7:0]  s1_ch_r;
  logic        s1_last_r;
  logic        s1_func_r;

  // Output register.
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic [31:0] out_value_r;

  logic               out_free;
  logic               s1_go;
  logic               in_take;
  dqp_pkg::parse_st_t st_upd;
  logic [31:0]        res_value;

  // A character that ends a string needs room in the output register; any
  // other character moves on at once.
  assign out_free = !out_valid_r || !out_stall;
  assign s1_go    = s1_valid_r && (!s1_last_r || out_free);
  assign in_stall = s1_valid_r && !s1_go;
  assign in_take  = in_valid && !in_stall;

  dqp_parse_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (s1_go),
    .ch     (s1_ch_r),
    .last   (s1_last_r),
    .func   (s1_func_r),
    .st_upd (st_upd)
  );

  dqp_result u_result (
    .st    (st_upd),
    .value (res_value)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_go && s1_last_r) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers load without reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_ch_r   <= in_ch;
      s1_last_r <= in_last;
      s1_func_r <= in_func;
    end
    if (s1_go && s1_last_r) begin
      out_value_r <= res_value;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

endmodule
`default_nettype wire

/* verif/dotted_quad_and_netmask_parser_tb.sv */
// Self-checking testbench for the dotted-quad and CIDR netmask parser.
module dotted_quad_and_netmask_parser_tb;
  import dqp_pkg::*;

  // The watchdog ends the run after this many cycles with no word moving on
  // either channel. The longest quiet stretch in a correct run is one long
  // sender gap plus one long receiver stall.
  localparam int QUIET_LIMIT = 2000;
  // The result passes the input and output registers after the last character
  // is taken; the tail after the final word catches a stray extra result.
  localparam int TAIL_CYCLES = 8;

  // One character word as the sender presents it. A word marked wait_drain
  // is held back until every parsed value in flight has been checked.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       func;
    logic       wait_drain;
  } text_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_ch = '0;
  logic        in_last = 1'b0;
  logic        in_func = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_value;

  dotted_quad_and_netmask_parser DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_ch     (in_ch),
    .in_last   (in_last),
    .in_func   (in_func),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_value (out_value)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Stimulus waiting to be sent, and the parsed values we expect back in order.
  text_word_t  pending_words[$];
  logic [31:0] parsed_value_q[$];
  logic [7:0]  text_buf[$];
  logic        drain_next = 1'b0;

  int strings_queued = 0;
  int words_sent = 0;
  int strings_sent = 0;
  int values_checked = 0;
  int drain_pauses = 0;
  int fail_count = 0;

  // ---------------------------------------------------------------------------
  // Parser predictor. It mirrors the block's state one character at a time:
  // up to four octets are collected between dots, each octet read like C atoi
  // (blanks, optional sign, digits, value kept modulo 256). In mask mode a
  // slash as the very first character switches to prefix-length reading.
  // ---------------------------------------------------------------------------
  logic [7:0] seen_octet [4];
  logic [7:0] digit_acc;
  phase_t     num_phase;
  logic       minus_sign;
  logic [1:0] dots_seen;
  logic       quad_full;
  logic       text_ended;
  logic       await_first;
  logic       mask_mode;
  logic       prefix_mode;
  logic [5:0] prefix_len;

  task automatic clear_parse();
    for (int i = 0; i < 4; i++) seen_octet[i] = '0;
    digit_acc   = '0;
    num_phase   = PH_SKIPWS;
    minus_sign  = 1'b0;
    dots_seen   = '0;
    quad_full   = 1'b0;
    text_ended  = 1'b0;
    await_first = 1'b1;
    mask_mode   = 1'b0;
    prefix_mode = 1'b0;
    prefix_len  = '0;
  endtask

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  // A minus sign negates the accumulated field in two's complement, 8 bits wide.
  function automatic logic [7:0] octet_now();
    return minus_sign ? (~digit_acc + 8'd1) : digit_acc;
  endfunction

  task automatic take_digit(input logic [3:0] d);
    int grown;
    if (prefix_mode) begin
      // The prefix length saturates one past the longest legal prefix.
      grown = prefix_len * 10 + d;
      prefix_len = (grown > CIDR_SAT) ? CIDR_SAT : grown[5:0];
    end else begin
      digit_acc = digit_acc * 8'd10 + d;
    end
  endtask

  task automatic feed_field(input logic [7:0] c);
    logic is_digit;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    case (num_phase)
      PH_SKIPWS: begin
        if (!is_blank(c)) begin
          if (c == CH_PLUS || c == CH_MINUS) begin
            minus_sign = (c == CH_MINUS);
            num_phase  = PH_DIGITS;
          end else if (is_digit) begin
            take_digit(4'(c - CH_ZERO));
            num_phase = PH_DIGITS;
          end else begin
            num_phase = PH_DONE;
          end
        end
      end
      PH_DIGITS: begin
        if (is_digit) take_digit(4'(c - CH_ZERO));
        else num_phase = PH_DONE;
      end
      default: ;
    endcase
  endtask

  task automatic finish_value(output logic [31:0] v);
    if (prefix_mode) begin
      // A minus-signed, zero or oversized prefix length gives an empty mask.
      if (minus_sign || prefix_len == 0 || prefix_len > CIDR_MAX) v = '0;
      else v = ALL_ONES << (32 - prefix_len);
    end else begin
      // Without three dots there is no address at all.
      if (quad_full) v = {seen_octet[0], seen_octet[1], seen_octet[2], octet_now()};
      else v = '0;
      // A dotted mask with its top bit clear is taken as a wildcard and inverted.
      if (mask_mode && !v[31]) v = ~v;
    end
  endtask

  task automatic parse_char(input logic [7:0] c, input logic last, input logic func,
                            output logic got, output logic [31:0] v);
    logic first;
    first = await_first;
    if (first) begin
      mask_mode   = func;
      await_first = 1'b0;
    end
    // After a zero byte the rest of the string is ignored until its last word.
    if (!text_ended) begin
      if (c == CH_NUL) begin
        text_ended = 1'b1;
      end else if (first && mask_mode && c == CH_SLASH) begin
        prefix_mode = 1'b1;
      end else if (!prefix_mode && c == CH_DOT && !quad_full) begin
        seen_octet[dots_seen] = octet_now();
        digit_acc  = '0;
        minus_sign = 1'b0;
        num_phase  = PH_SKIPWS;
        if (dots_seen == 2'd2) quad_full = 1'b1;
        dots_seen = dots_seen + 2'd1;
      end else begin
        // Once three dots are in, any further dot simply ends the last field.
        feed_field(c);
      end
    end
    got = last;
    v   = '0;
    if (last) begin
      finish_value(v);
      clear_parse();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus building. Text is collected in text_buf and then split into words;
  // func only matters on the first word, so later words carry a random func.
  // ---------------------------------------------------------------------------
  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endtask

  task automatic send_text(input logic func);
    text_word_t w;
    for (int i = 0; i < text_buf.size(); i++) begin
      w.ch         = text_buf[i];
      w.last       = (i == text_buf.size() - 1);
      w.func       = (i == 0) ? func : 1'($urandom_range(0, 1));
      w.wait_drain = (i == 0) && drain_next;
      pending_words.push_back(w);
    end
    drain_next = 1'b0;
    text_buf.delete();
    strings_queued++;
  endtask

  // One atoi-style number: sometimes leading blanks, a sign or a leading zero.
  task automatic put_number(input logic for_prefix);
    int n;
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) text_buf.push_back(CH_SPACE);
    if (r < 8) text_buf.push_back(CH_TAB + 8'($urandom_range(0, 4)));
    case ($urandom_range(0, 7))
      0: text_buf.push_back(CH_PLUS);
      1: text_buf.push_back(CH_MINUS);
      default: ;
    endcase
    r = $urandom_range(0, 99);
    if (for_prefix) n = (r < 75) ? $urandom_range(0, 32) : $urandom_range(33, 500);
    else if (r < 70) n = $urandom_range(0, 255);
    else if (r < 90) n = $urandom_range(256, 999);
    else n = $urandom_range(1000, 99999);
    if ($urandom_range(0, 9) == 0) text_buf.push_back(CH_ZERO);
    put_text($sformatf("%0d", n));
  endtask

  task automatic put_quad(input int n_dots);
    for (int k = 0; k <= n_dots; k++) begin
      put_number(1'b0);
      if (k < n_dots) text_buf.push_back(CH_DOT);
    end
  endtask

  // Mostly well-formed addresses and masks with random content; the rest are
  // strings with a random number of dots, some with a zero byte, or raw noise.
  task automatic queue_random_string();
    int kind;
    int n_dots;
    logic func;
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      func = 1'b0;
      put_quad(3);
    end else if (kind < 55) begin
      func = 1'b1;
      put_quad(3);
    end else if (kind < 75) begin
      func = 1'b1;
      text_buf.push_back(CH_SLASH);
      put_number(1'b1);
    end else if (kind < 87) begin
      func = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 4))
        0: n_dots = 0;
        1: n_dots = 1;
        2: n_dots = 2;
        3: n_dots = 4;
        default: n_dots = 3;
      endcase
      put_quad(n_dots);
      if ($urandom_range(0, 1) == 1)
        text_buf.insert($urandom_range(0, text_buf.size() - 1), CH_NUL);
    end else begin
      func = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 2) == 0) text_buf.push_back(CH_SLASH);
      repeat ($urandom_range(1, 8)) text_buf.push_back(8'($urandom_range(0, 255)));
    end
    // Some strings carry trailing junk after the last field.
    if (kind < 75 && $urandom_range(0, 4) == 0)
      text_buf.push_back(8'($urandom_range(8'h21, 8'h7e)));
    send_text(func);
  endtask

  // Gap lengths for both sides: mostly none or short, a few long, and now and
  // then a calm stretch with no gaps at all.
  task automatic pick_gap(inout int calm_left, output int gap);
    int r;
    r = $urandom_range(0, 99);
    if (calm_left > 0) begin
      calm_left--;
      gap = 0;
    end else if (r < 2) begin
      calm_left = $urandom_range(20, 60);
      gap = 0;
    end else if (r < 55) begin
      gap = 0;
    end else if (r < 90) begin
      gap = $urandom_range(1, 3);
    end else begin
      gap = $urandom_range(8, 30);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver. A character word is predicted at the edge where it is accepted;
  // the next word, or a gap, is chosen in the same step so that in_valid gets
  // a single assignment per edge. A stalled word is held unchanged.
  // ---------------------------------------------------------------------------
  text_word_t  next_word;
  logic        drive_valid;
  logic        got_value;
  logic [31:0] predicted_value;
  int          send_gap = 0;
  int          send_calm = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      drive_valid = in_valid;
      if (in_valid && !in_stall) begin
        parse_char(in_ch, in_last, in_func, got_value, predicted_value);
        if (got_value) begin
          parsed_value_q.push_back(predicted_value);
          strings_sent++;
        end
        words_sent++;
        drive_valid = 1'b0;
        pick_gap(send_calm, send_gap);
      end
      if (!drive_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_words.size() > 0 &&
                     (!pending_words[0].wait_drain || parsed_value_q.size() == 0)) begin
          next_word = pending_words.pop_front();
          if (next_word.wait_drain) drain_pauses++;
          in_ch   <= next_word.ch;
          in_last <= next_word.last;
          in_func <= next_word.func;
          drive_valid = 1'b1;
        end
      end
      in_valid <= drive_valid;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. Each accepted value is checked against the oldest prediction;
  // out_stall is toggled in random runs independent of out_valid.
  // ---------------------------------------------------------------------------
  logic [31:0] expected_value;
  int          stall_left = 0;
  int          recv_calm = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (parsed_value_q.size() == 0) begin
          $error("value %08h arrived with no string outstanding", out_value);
          fail_count++;
        end else begin
          expected_value = parsed_value_q.pop_front();
          values_checked++;
          if (out_value !== expected_value) begin
            $error("value mismatch: expected %08h, actual %08h", expected_value, out_value);
            fail_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        pick_gap(recv_calm, stall_left);
      end
    end
  end

  // Watchdog: a stuck handshake on either side ends the run as a failure.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles, %0d values outstanding",
                 QUIET_LIMIT, parsed_value_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence: directed strings first, then random strings, with the
  // sender pausing for a full drain at a few points along the way.
  // ---------------------------------------------------------------------------
  int directed_words;

  initial begin
    clear_parse();

    // Octet extremes, then wraparound, a minus sign and leading blanks.
    put_text("255.0.9.1");         send_text(1'b0);
    put_text("256.-1. +7.\t300");  send_text(1'b0);
    // Too few dots: zero for an address, all ones for a mask.
    put_text("1.2");               send_text(1'b0);
    put_text("1.2");               send_text(1'b1);
    // Dots past the third only end the last field.
    put_text("1.2.3.4.5");         send_text(1'b0);
    // A zero byte cuts the string short, even as its first character.
    put_text("1.2"); text_buf.push_back(CH_NUL); put_text(".3.4"); send_text(1'b0);
    text_buf.push_back(CH_NUL);    send_text(1'b0);
    text_buf.push_back(CH_NUL);    send_text(1'b1);
    // Prefix lengths: saturated, zero, signed, both legal ends, blanks and plus.
    put_text("/99999");            send_text(1'b1);
    put_text("/0");                send_text(1'b1);
    put_text("/-8");               send_text(1'b1);
    put_text("/32");               send_text(1'b1);
    put_text("/1");                send_text(1'b1);
    put_text("/ +24");             send_text(1'b1);
    // Dotted masks with the top bit set and clear.
    put_text("255.255.0.0");       send_text(1'b1);
    put_text("0.0.255.255");       send_text(1'b1);
    // Single-character strings, a slash in address mode, a high byte in a field.
    put_text("/");                 send_text(1'b0);
    put_text("/");                 send_text(1'b1);
    put_text("x");                 send_text(1'b0);
    put_text("1."); text_buf.push_back(8'hff); put_text(".3.4"); send_text(1'b0);

    // About a hundred directed characters, topped up to about 400 in all.
    directed_words = pending_words.size();
    drain_next = 1'b1;
    while (pending_words.size() < directed_words + 300) begin
      if ((strings_queued % 12) == 0) drain_next = 1'b1;
      queue_random_string();
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_words.size() != 0 || in_valid) @(posedge clk);
    while (parsed_value_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d characters in %0d strings (addresses, dotted and prefix masks, noise).",
             words_sent, strings_sent);
    $display("Checked %0d parsed values; the sender paused for a full drain %0d times.",
             values_checked, drain_pauses);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* dotted_quad_and_netmask_parser.f */
sv/dqp_pkg.sv
sv/dqp_parse_core.sv
sv/dqp_result.sv
sv/dotted_quad_and_netmask_parser.sv
verif/dotted_quad_and_netmask_parser_tb.sv
